// ===== rtl/blifo_pkg.sv =====
// Shared constants and types for the bounded LIFO stack.
package blifo_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = 7;
    localparam int DATA_W = 32;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;
    localparam int OUT_TDATA_W = 48;

    localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(64);

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_PEEK = 2'd2,
        CMD_DUMP = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_OVER  = 2'd1,
        ST_UNDER = 2'd2
    } t_status;

endpackage

// ===== rtl/bounded_lifo_stack.sv =====
// Bounded LIFO stack of 32-bit words held in a single synchronous memory.
// Push: result registered when accepted, one push per cycle unless stalled.
// Pop and peek: result passes the read-data register, then the output register.
// Dump of N entries: N results, one per cycle unless the output stalls.
// The single read port of the entry memory sets the dump rate.
// Reset clears the count and sets capacity to 64; memory contents are not cleared.
module bounded_lifo_stack (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [blifo_pkg::CNT_W-1:0]        i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // Fields from bit 0: push_value.
    input  logic [blifo_pkg::DATA_W-1:0]       s_axis_tdata,
    // Fields from bit 0: cmd.
    input  logic [blifo_pkg::CMD_W-1:0]        s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // Fields from bit 0: data_value, is_empty, is_full, fill_count, zero padding.
    output logic [blifo_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // Fields from bit 0: status.
    output logic [blifo_pkg::STAT_W-1:0]       m_axis_tuser,
    output logic                               m_axis_tlast
);
    import blifo_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DUMP
    } t_state;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    t_state            r_state,      n_state;
    logic [CNT_W-1:0]  r_count,      n_count;
    logic [CNT_W-1:0]  r_idx,        n_idx;
    logic [CNT_W-1:0]  r_cap;
    logic              r_out_valid,  n_out_valid;
    t_status           r_out_status, n_out_status;
    logic [DATA_W-1:0] r_out_data,   n_out_data;
    logic              r_out_last,   n_out_last;
    logic              r_out_empty,  n_out_empty;
    logic              r_out_full,   n_out_full;
    logic [CNT_W-1:0]  r_out_count,  n_out_count;

    logic [CNT_W-1:0]  eff_cap;
    logic [CNT_W-1:0]  cnt_p1;
    logic [CNT_W-1:0]  cnt_m1;
    logic [CNT_W-1:0]  idx_p1;
    logic              out_free;
    logic              in_acc;
    logic              load;
    t_status           ld_status;
    logic [DATA_W-1:0] ld_data;
    logic              ld_last;
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    t_cmd              cmd;

    assign o_cfg_ready   = 1'b1;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && out_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign cmd           = t_cmd'(s_axis_tuser);
    assign cnt_p1        = r_count + CNT_W'(1);
    assign cnt_m1        = r_count - CNT_W'(1);
    assign idx_p1        = r_idx + CNT_W'(1);

    always_comb begin
        if (r_cap > DEPTH_C) begin
            eff_cap = DEPTH_C;
        end else if (r_cap == '0) begin
            eff_cap = CNT_W'(1);
        end else begin
            eff_cap = r_cap;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        load      = 1'b0;
        ld_status = ST_OK;
        ld_data   = '0;
        ld_last   = 1'b1;
        wr_en     = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = '0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (cmd)
                        CMD_PUSH: begin
                            load = 1'b1;
                            if (r_count >= eff_cap || r_count >= DEPTH_C) begin
                                ld_status = ST_OVER;
                            end else begin
                                wr_en   = 1'b1;
                                n_count = cnt_p1;
                            end
                        end
                        CMD_POP, CMD_PEEK: begin
                            if (r_count == '0 || r_count > DEPTH_C) begin
                                load      = 1'b1;
                                ld_status = ST_UNDER;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = cnt_m1[ADDR_W-1:0];
                                n_state = S_READ;
                                if (cmd == CMD_POP) begin
                                    n_count = cnt_m1;
                                end
                            end
                        end
                        CMD_DUMP: begin
                            if (r_count == '0 || r_count > DEPTH_C) begin
                                load      = 1'b1;
                                ld_status = ST_UNDER;
                            end else begin
                                rd_en   = 1'b1;
                                n_idx   = '0;
                                n_state = S_DUMP;
                            end
                        end
                        default: begin
                            load      = 1'b1;
                            ld_status = ST_UNDER;
                        end
                    endcase
                end
            end
            S_READ: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_data = r_rd_data;
                    n_state = S_IDLE;
                end
            end
            S_DUMP: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_data = r_rd_data;
                    ld_last = (idx_p1 == r_count);
                    if (idx_p1 == r_count) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = idx_p1;
                        rd_en   = 1'b1;
                        rd_addr = idx_p1[ADDR_W-1:0];
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_status = r_out_status;
        n_out_data   = r_out_data;
        n_out_last   = r_out_last;
        n_out_empty  = r_out_empty;
        n_out_full   = r_out_full;
        n_out_count  = r_out_count;
        if (load) begin
            n_out_valid  = 1'b1;
            n_out_status = ld_status;
            n_out_data   = ld_data;
            n_out_last   = ld_last;
            n_out_empty  = (n_count == '0);
            n_out_full   = (n_count >= eff_cap);
            n_out_count  = n_count;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_count[ADDR_W-1:0]] <= s_axis_tdata;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
        end
        r_out_status <= n_out_status;
        r_out_data   <= n_out_data;
        r_out_last   <= n_out_last;
        r_out_empty  <= n_out_empty;
        r_out_full   <= n_out_full;
        r_out_count  <= n_out_count;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {{(OUT_TDATA_W - DATA_W - CNT_W - 2){1'b0}},
                            r_out_count, r_out_full, r_out_empty, r_out_data};

endmodule
